>>> sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every clock edge out of reset.
`define MC_ASSERT(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Check that a condition implies a consequence at the same clock edge.
`define MC_ASSERT_IMPL(label, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) \
		else $error(msg);

`endif

>>> sv/mcomp_pkg.sv
`default_nettype none

package mcomp_pkg;

	localparam int RAW_W      = 16;
	localparam int GAIN_W     = 16;
	localparam int DECL_W     = 19;
	localparam int FIELD_W    = 24;
	localparam int HEAD_W     = 9;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 19;

	localparam logic [CFG_IDX_W-1:0] CFG_AXIS_GAIN   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_DECLINATION = 1'b1;

	localparam logic [GAIN_W-1:0]        GAIN_RESET = 16'd60293;
	localparam logic signed [DECL_W-1:0] DECL_RESET = 19'sd3908;

	localparam int CORDIC_STEPS_DEF = 16;

	// CORDIC datapath: vector components and Q16 radian angle
	localparam int CXY_W = 35;
	localparam int ANG_W = 22;
	localparam logic signed [ANG_W-1:0] ANG_PI     = 22'sd205887;
	localparam logic signed [ANG_W-1:0] ANG_TWO_PI = 22'sd411775;

	// wrapped heading (0..2pi, Q16 rad) and Q16 degrees
	localparam int HR_W  = 19;
	localparam int RAD_W = 22;
	localparam int DEG_W = 25;
	localparam logic [RAD_W-1:0] RAD_TO_DEG_Q16 = 22'd3754936;

	localparam logic [HEAD_W-1:0] HEAD_MAX = 9'd360;

	typedef struct packed {
		logic [7:0] x_high_byte;
		logic [7:0] x_low_byte;
		logic [7:0] y_high_byte;
		logic [7:0] y_low_byte;
		logic [7:0] z_high_byte;
		logic [7:0] z_low_byte;
	} sample_t;

	typedef struct packed {
		logic signed [FIELD_W-1:0] field_x;
		logic signed [FIELD_W-1:0] field_y;
		logic signed [FIELD_W-1:0] field_z;
		logic [HEAD_W-1:0]         heading_degrees;
	} result_t;

	typedef struct packed {
		logic signed [FIELD_W-1:0] field_x;
		logic signed [FIELD_W-1:0] field_y;
		logic signed [FIELD_W-1:0] field_z;
	} axes_t;

	typedef struct packed {
		axes_t                   axes;
		logic                    zero;
		logic signed [CXY_W-1:0] x;
		logic signed [CXY_W-1:0] y;
		logic signed [ANG_W-1:0] z;
	} rot_t;

	// round(atan(2^-i) * 65536)
	function automatic logic signed [ANG_W-1:0] atan_entry(input int idx);
		logic signed [ANG_W-1:0] a;
		unique case (idx)
			0:       a = 22'sd51472;
			1:       a = 22'sd30385;
			2:       a = 22'sd16055;
			3:       a = 22'sd8150;
			4:       a = 22'sd4091;
			5:       a = 22'sd2047;
			6:       a = 22'sd1024;
			7:       a = 22'sd512;
			8:       a = 22'sd256;
			9:       a = 22'sd128;
			10:      a = 22'sd64;
			11:      a = 22'sd32;
			12:      a = 22'sd16;
			13:      a = 22'sd8;
			14:      a = 22'sd4;
			15:      a = 22'sd2;
			16:      a = 22'sd1;
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

`default_nettype wire

>>> sv/mcomp_scale.sv
`default_nettype none

module mcomp_scale (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [mcomp_pkg::GAIN_W-1:0]  gain,
	input  logic                          up_valid,
	output logic                          up_ready,
	input  mcomp_pkg::sample_t            up_sample,
	output logic                          dn_valid,
	input  logic                          dn_ready,
	output mcomp_pkg::axes_t              dn_axes
);

	localparam int SHIFT = 8;

	logic             vld_s1;
	mcomp_pkg::axes_t axes_s1;

	// join the bytes, multiply by the unsigned gain, drop eight fraction bits
	function automatic logic signed [mcomp_pkg::FIELD_W-1:0] scale_axis(
		input logic [7:0] hi,
		input logic [7:0] lo,
		input logic [mcomp_pkg::GAIN_W-1:0] g
	);
		logic signed [mcomp_pkg::RAW_W+mcomp_pkg::GAIN_W:0] p;
		p = $signed({hi, lo}) * $signed({1'b0, g});
		return p[mcomp_pkg::FIELD_W+SHIFT-1:SHIFT];
	endfunction

	assign up_ready = !vld_s1 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (up_ready) begin
			vld_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			axes_s1.field_x <= scale_axis(up_sample.x_high_byte, up_sample.x_low_byte, gain);
			axes_s1.field_y <= scale_axis(up_sample.y_high_byte, up_sample.y_low_byte, gain);
			axes_s1.field_z <= scale_axis(up_sample.z_high_byte, up_sample.z_low_byte, gain);
		end
	end

	assign dn_valid = vld_s1;
	assign dn_axes  = axes_s1;

endmodule

`default_nettype wire

>>> sv/mcomp_cordic.sv
`default_nettype none

module mcomp_cordic #(
	parameter int STEPS = mcomp_pkg::CORDIC_STEPS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              up_valid,
	output logic              up_ready,
	input  mcomp_pkg::axes_t  up_axes,
	output logic              dn_valid,
	input  logic              dn_ready,
	output mcomp_pkg::rot_t   dn_rot
);

	localparam int PAD = mcomp_pkg::CXY_W - mcomp_pkg::FIELD_W - 8;

	// stage 0 is the pre-rotation, stage k holds the vector after k iterations
	mcomp_pkg::rot_t rot_s [STEPS+1];
	mcomp_pkg::rot_t nxt_s [STEPS+1];
	logic [STEPS:0]   vld_s;
	logic [STEPS:0]   vin_s;
	logic [STEPS+1:0] ld_s;

	function automatic mcomp_pkg::rot_t cordic_iter(input mcomp_pkg::rot_t r, input int sh);
		mcomp_pkg::rot_t n;
		n = r;
		if (r.y < 0) begin
			n.x = r.x - (r.y >>> sh);
			n.y = r.y + (r.x >>> sh);
			n.z = r.z - mcomp_pkg::atan_entry(sh);
		end else begin
			n.x = r.x + (r.y >>> sh);
			n.y = r.y - (r.x >>> sh);
			n.z = r.z + mcomp_pkg::atan_entry(sh);
		end
		return n;
	endfunction

	// scale up by 256; fold the left half-plane over by pi
	always_comb begin
		nxt_s[0].axes = up_axes;
		nxt_s[0].zero = (up_axes.field_x == '0) && (up_axes.field_y == '0);
		nxt_s[0].x    = $signed({{PAD{up_axes.field_x[mcomp_pkg::FIELD_W-1]}},
			up_axes.field_x, 8'd0});
		nxt_s[0].y    = $signed({{PAD{up_axes.field_y[mcomp_pkg::FIELD_W-1]}},
			up_axes.field_y, 8'd0});
		nxt_s[0].z    = '0;
		if (up_axes.field_x < 0) begin
			nxt_s[0].z = (up_axes.field_y < 0) ? -mcomp_pkg::ANG_PI : mcomp_pkg::ANG_PI;
			nxt_s[0].x = -nxt_s[0].x;
			nxt_s[0].y = -nxt_s[0].y;
		end
	end

	for (genvar k = 1; k <= STEPS; k++) begin : g_iter
		assign nxt_s[k] = cordic_iter(rot_s[k-1], k - 1);
	end

	assign vin_s          = {vld_s[STEPS-1:0], up_valid};
	assign ld_s[STEPS+1]  = dn_ready;

	for (genvar k = 0; k <= STEPS; k++) begin : g_ready
		assign ld_s[k] = !vld_s[k] || ld_s[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int k = 0; k <= STEPS; k++) begin
				if (ld_s[k]) begin
					vld_s[k] <= vin_s[k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k <= STEPS; k++) begin
			if (ld_s[k] && vin_s[k]) begin
				rot_s[k] <= nxt_s[k];
			end
		end
	end

	assign up_ready = ld_s[0];
	assign dn_valid = vld_s[STEPS];
	assign dn_rot   = rot_s[STEPS];

endmodule

`default_nettype wire

>>> sv/mcomp_heading.sv
`default_nettype none

module mcomp_heading (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic signed [mcomp_pkg::DECL_W-1:0] decl,
	input  logic                                up_valid,
	output logic                                up_ready,
	input  mcomp_pkg::rot_t                     up_rot,
	output logic                                dn_valid,
	input  logic                                dn_ready,
	output mcomp_pkg::result_t                  dn_result
);

	localparam int NSTG    = 7;
	localparam int ANG_W   = mcomp_pkg::ANG_W;
	localparam int HR_W    = mcomp_pkg::HR_W;
	localparam int DEG_W   = mcomp_pkg::DEG_W;
	localparam int PROD3_W = HR_W + mcomp_pkg::RAD_W;
	localparam int NUM_W   = 30;
	localparam int RECIP_W = 28;
	localparam int RSH     = 32;
	localparam int PROD5_W = NUM_W + RECIP_W;
	localparam int Q_W     = PROD5_W - RSH;
	localparam int DEN_W   = 8;
	localparam int Q16     = 65536;

	localparam logic [DEG_W-1:0] EDGE_1   = DEG_W'(Q16);
	localparam logic [DEG_W-1:0] EDGE_180 = DEG_W'(180 * Q16);
	localparam logic [DEG_W-1:0] EDGE_205 = DEG_W'(205 * Q16);
	localparam logic [DEG_W-1:0] EDGE_265 = DEG_W'(265 * Q16);
	localparam logic [DEG_W-1:0] OFS_90   = DEG_W'(90 * Q16);
	localparam logic [DEG_W-1:0] OFS_180  = DEG_W'(180 * Q16);
	localparam logic [DEG_W-1:0] OFS_270  = DEG_W'(270 * Q16);
	localparam logic [DEG_W:0]   HALF     = (DEG_W+1)'(Q16 / 2);

	localparam logic [NUM_W-1:0] K_ONE = NUM_W'(1);
	localparam logic [NUM_W-1:0] K_89  = NUM_W'(89);
	localparam logic [NUM_W-1:0] K_90  = NUM_W'(90);

	localparam logic [DEN_W-1:0] DEN_LOW   = DEN_W'(179);
	localparam logic [DEN_W-1:0] DEN_MID   = DEN_W'(24);
	localparam logic [DEN_W-1:0] DEN_UPPER = DEN_W'(59);
	localparam logic [DEN_W-1:0] DEN_TOP   = DEN_W'(95);

	localparam logic [RECIP_W-1:0] RECIP_LOW   = RECIP_W'((64'd1 << RSH) / 179);
	localparam logic [RECIP_W-1:0] RECIP_MID   = RECIP_W'((64'd1 << RSH) / 24);
	localparam logic [RECIP_W-1:0] RECIP_UPPER = RECIP_W'((64'd1 << RSH) / 59);
	localparam logic [RECIP_W-1:0] RECIP_TOP   = RECIP_W'((64'd1 << RSH) / 95);

	// calibration band of a Q16 degree value
	typedef enum logic [2:0] {
		BAND_PASS  = 3'd0,
		BAND_LOW   = 3'd1,
		BAND_MID   = 3'd2,
		BAND_UPPER = 3'd3,
		BAND_TOP   = 3'd4
	} band_t;

	logic [NSTG:1]   vld_s;
	logic [NSTG:1]   vin_s;
	logic [NSTG+1:1] ld_s;
	logic [NSTG:1]   en_s;

	mcomp_pkg::axes_t axes_s [1:NSTG];

	logic signed [ANG_W-1:0] ang_s1;
	logic [HR_W-1:0]         wrap_s2;
	logic [DEG_W-1:0]        deg_s3;
	logic [NUM_W-1:0]        num_s4, num_s5;
	band_t                   band_s4, band_s5, band_s6;
	logic [Q_W-1:0]          q0_s5, q_s6;
	logic [mcomp_pkg::HEAD_W-1:0] head_s7;

	logic signed [ANG_W-1:0] zeff, diff1, ang1, ang2;
	logic [PROD3_W-1:0]      prod3;
	band_t                   band4;
	logic [DEG_W-1:0]        base4;
	logic [NUM_W-1:0]        gain4, num4;
	logic [RECIP_W-1:0]      recip5;
	logic [PROD5_W-1:0]      prod5;
	logic [DEN_W-1:0]        den6;
	logic [NUM_W-1:0]        rem6;
	logic [Q_W-1:0]          q6;
	logic [DEG_W-1:0]        ofs7, cal7;
	logic [DEG_W:0]          rnd7;

	// handshake: a stage loads when empty or when its word moves on
	assign vin_s        = {vld_s[NSTG-1:1], up_valid};
	assign ld_s[NSTG+1] = dn_ready;
	for (genvar k = 1; k <= NSTG; k++) begin : g_ready
		assign ld_s[k] = !vld_s[k] || ld_s[k+1];
	end
	assign en_s = ld_s[NSTG:1] & vin_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int k = 1; k <= NSTG; k++) begin
				if (ld_s[k]) begin
					vld_s[k] <= vin_s[k];
				end
			end
		end
	end

	// stage 1: subtract declination, first wrap pass
	always_comb begin
		zeff  = up_rot.zero ? '0 : up_rot.z;
		diff1 = zeff - ANG_W'(decl);
		ang1  = diff1;
		if (diff1 < 0) begin
			ang1 = diff1 + mcomp_pkg::ANG_TWO_PI;
		end else if (diff1 > mcomp_pkg::ANG_TWO_PI) begin
			ang1 = diff1 - mcomp_pkg::ANG_TWO_PI;
		end
	end

	// stage 2: second wrap pass
	always_comb begin
		ang2 = ang_s1;
		if (ang_s1 < 0) begin
			ang2 = ang_s1 + mcomp_pkg::ANG_TWO_PI;
		end else if (ang_s1 > mcomp_pkg::ANG_TWO_PI) begin
			ang2 = ang_s1 - mcomp_pkg::ANG_TWO_PI;
		end
	end

	// stage 3: radians to Q16 degrees
	assign prod3 = PROD3_W'(wrap_s2) * PROD3_W'(mcomp_pkg::RAD_TO_DEG_Q16);

	// stage 4: pick the band, form the scaled numerator
	always_comb begin
		band4 = BAND_TOP;
		base4 = EDGE_265;
		gain4 = K_90;
		priority if (deg_s3 < EDGE_1) begin
			band4 = BAND_PASS;
			base4 = '0;
			gain4 = K_ONE;
		end else if (deg_s3 < EDGE_180) begin
			band4 = BAND_LOW;
			base4 = '0;
			gain4 = K_89;
		end else if (deg_s3 < EDGE_205) begin
			band4 = BAND_MID;
			base4 = EDGE_180;
			gain4 = K_89;
		end else if (deg_s3 < EDGE_265) begin
			band4 = BAND_UPPER;
			base4 = EDGE_205;
			gain4 = K_89;
		end else begin
			band4 = BAND_TOP;
			base4 = EDGE_265;
			gain4 = K_90;
		end
		num4 = NUM_W'(deg_s3 - base4) * gain4;
	end

	// stage 5: quotient estimate by reciprocal, low by at most one
	always_comb begin
		unique case (band_s4)
			BAND_LOW:   recip5 = RECIP_LOW;
			BAND_MID:   recip5 = RECIP_MID;
			BAND_UPPER: recip5 = RECIP_UPPER;
			BAND_TOP:   recip5 = RECIP_TOP;
			default:    recip5 = '0;
		endcase
		prod5 = PROD5_W'(num_s4) * PROD5_W'(recip5);
	end

	// stage 6: fix the estimate with one compare
	always_comb begin
		unique case (band_s5)
			BAND_LOW:   den6 = DEN_LOW;
			BAND_MID:   den6 = DEN_MID;
			BAND_UPPER: den6 = DEN_UPPER;
			BAND_TOP:   den6 = DEN_TOP;
			default:    den6 = '1;
		endcase
		rem6 = num_s5 - NUM_W'(q0_s5) * NUM_W'(den6);
		if (band_s5 == BAND_PASS) begin
			q6 = Q_W'(num_s5);
		end else if (rem6 >= NUM_W'(den6)) begin
			q6 = q0_s5 + Q_W'(1);
		end else begin
			q6 = q0_s5;
		end
	end

	// stage 7: add band offset, round half up, clamp
	always_comb begin
		unique case (band_s6)
			BAND_MID:   ofs7 = OFS_90;
			BAND_UPPER: ofs7 = OFS_180;
			BAND_TOP:   ofs7 = OFS_270;
			default:    ofs7 = '0;
		endcase
		cal7 = DEG_W'(q_s6) + ofs7;
		rnd7 = (DEG_W+1)'(cal7) + HALF;
	end

	always_ff @(posedge clk) begin
		if (en_s[1]) begin
			axes_s[1] <= up_rot.axes;
			ang_s1    <= ang1;
		end
		if (en_s[2]) begin
			axes_s[2] <= axes_s[1];
			wrap_s2   <= ang2[HR_W-1:0];
		end
		if (en_s[3]) begin
			axes_s[3] <= axes_s[2];
			deg_s3    <= prod3[PROD3_W-1:16];
		end
		if (en_s[4]) begin
			axes_s[4] <= axes_s[3];
			band_s4   <= band4;
			num_s4    <= num4;
		end
		if (en_s[5]) begin
			axes_s[5] <= axes_s[4];
			band_s5   <= band_s4;
			num_s5    <= num_s4;
			q0_s5     <= prod5[PROD5_W-1:RSH];
		end
		if (en_s[6]) begin
			axes_s[6] <= axes_s[5];
			band_s6   <= band_s5;
			q_s6      <= q6;
		end
		if (en_s[7]) begin
			axes_s[7] <= axes_s[6];
			if (rnd7[DEG_W:16] > (DEG_W-15)'(mcomp_pkg::HEAD_MAX)) begin
				head_s7 <= mcomp_pkg::HEAD_MAX;
			end else begin
				head_s7 <= rnd7[16+mcomp_pkg::HEAD_W-1:16];
			end
		end
	end

	assign up_ready                  = ld_s[1];
	assign dn_valid                  = vld_s[NSTG];
	assign dn_result.field_x         = axes_s[NSTG].field_x;
	assign dn_result.field_y         = axes_s[NSTG].field_y;
	assign dn_result.field_z         = axes_s[NSTG].field_z;
	assign dn_result.heading_degrees = head_s7;

endmodule

`default_nettype wire

>>> sv/magnetometer_compass_heading_top.sv
// Compass heading from one three-axis magnetometer sample. Each sample word carries the six
// raw bytes; the result holds the three axes scaled by axis_gain (unsigned Q8.8) and the
// calibrated heading in whole degrees, 0..360. The block is a fully pipelined datapath: one
// stage scales the axes, one folds the vector into the right half-plane, CORDIC_STEPS stages
// each run one CORDIC iteration, and seven stages wrap the angle, convert it to degrees and
// apply the piecewise-linear calibration, CORDIC_STEPS + 9 register stages in all. A sample
// can enter every clock unless a stalled result_ready has filled the pipeline. Every stage
// has its own valid bit and loads whenever it is empty or its word moves on, so a stalled
// result_ready holds the results in place while the empty stages behind them keep taking
// samples; nothing is dropped or repeated. Write axis_gain and declination_offset only
// while no sample is in flight; the config port has no read-back.
`default_nettype none
`include "assert_macros.svh"

module magnetometer_compass_heading_top #(
	parameter int CORDIC_STEPS = mcomp_pkg::CORDIC_STEPS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write_en,
	input  logic [mcomp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mcomp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                              sample_valid,
	output logic                              sample_ready,
	input  mcomp_pkg::sample_t                sample,
	output logic                              result_valid,
	input  logic                              result_ready,
	output mcomp_pkg::result_t                result
);

	// config registers, kept static by the user while samples are in flight; not enforced
	logic [mcomp_pkg::GAIN_W-1:0]        gain_q;
	logic signed [mcomp_pkg::DECL_W-1:0] decl_q;

	// scale -> cordic
	logic             scl_valid, scl_ready;
	mcomp_pkg::axes_t scl_axes;

	// cordic -> heading
	logic             rot_valid, rot_ready;
	mcomp_pkg::rot_t  rot_word;

	// Take a config write on any enabled clock; an unknown index is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= mcomp_pkg::GAIN_RESET;
			decl_q <= mcomp_pkg::DECL_RESET;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				mcomp_pkg::CFG_AXIS_GAIN:   gain_q <= cfg_wdata[mcomp_pkg::GAIN_W-1:0];
				mcomp_pkg::CFG_DECLINATION: decl_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Join the byte pairs and scale each axis by the gain: one stage.
	mcomp_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.gain      (gain_q),
		.up_valid  (sample_valid),
		.up_ready  (sample_ready),
		.up_sample (sample),
		.dn_valid  (scl_valid),
		.dn_ready  (scl_ready),
		.dn_axes   (scl_axes)
	);

	// Vectoring CORDIC: the vector's angle collects in z, the axes ride along.
	mcomp_cordic #(
		.STEPS (CORDIC_STEPS)
	) u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (scl_valid),
		.up_ready (scl_ready),
		.up_axes  (scl_axes),
		.dn_valid (rot_valid),
		.dn_ready (rot_ready),
		.dn_rot   (rot_word)
	);

	// Declination, wrap, degrees, calibration and rounding; last stage is the output register.
	mcomp_heading u_heading (
		.clk       (clk),
		.arst_n    (arst_n),
		.decl      (decl_q),
		.up_valid  (rot_valid),
		.up_ready  (rot_ready),
		.up_rot    (rot_word),
		.dn_valid  (result_valid),
		.dn_ready  (result_ready),
		.dn_result (result)
	);

	// An empty or draining output stage opens every stage behind it.
	`MC_ASSERT_IMPL(a_drain_open, result_ready || !result_valid, sample_ready, "input blocked")
	// Clamp keeps the heading in range.
	`MC_ASSERT_IMPL(a_head_rng, result_valid, result.heading_degrees <= mcomp_pkg::HEAD_MAX, "over 360")
	// A full pipeline only happens behind a stalled output.
	`MC_ASSERT_IMPL(a_full_stall, !sample_ready, result_valid && !result_ready, "no output stall")

endmodule

`default_nettype wire
